// ===== src/dcft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcft_pkg: shared types and constants for the day count to FAT timestamp unit
// Calendar constants, field widths, the result struct between the calendar
// sequencer and the top level, and the month length function.
// ----------------------------------------------------------------------------
package dcft_pkg;

	// Field widths
	localparam int DayCountW = 16;
	localparam int HourW     = 6;
	localparam int MinuteW   = 7;
	localparam int SecondW   = 7;
	localparam int DayW      = 5;
	localparam int MonthW    = 4;
	localparam int YearW     = 12;
	localparam int FatW      = 16;
	localparam int LenW      = 9;

	// Calendar constants
	localparam int EpochYearI    = 1978;
	localparam int FatEpochYearI = 1980;
	localparam logic [YearW-1:0] EpochYear    = YearW'(EpochYearI);
	localparam logic [YearW-1:0] FatEpochYear = YearW'(FatEpochYearI);
	localparam logic [LenW-1:0]  DaysYear     = LenW'(365);
	localparam logic [LenW-1:0]  DaysLeapYear = LenW'(366);
	localparam logic [MonthW-1:0] MonthJan    = MonthW'(1);
	localparam logic [MonthW-1:0] MonthFeb    = MonthW'(2);
	localparam logic [MonthW-1:0] MonthDec    = MonthW'(12);

	// Leap rule counters: year mod 4, mod 100, mod 400
	localparam int Mod4W   = 2;
	localparam int Mod100W = 7;
	localparam int Mod400W = 9;
	localparam logic [Mod100W-1:0] Cent     = Mod100W'(99);
	localparam logic [Mod400W-1:0] QuadCent = Mod400W'(399);
	localparam logic [Mod4W-1:0]   EpochMod4   = Mod4W'(EpochYearI % 4);
	localparam logic [Mod100W-1:0] EpochMod100 = Mod100W'(EpochYearI % 100);
	localparam logic [Mod400W-1:0] EpochMod400 = Mod400W'(EpochYearI % 400);

	// Calendar result handed from the sequencer to the output stage
	typedef struct packed {
		logic [DayW-1:0]   day;
		logic [MonthW-1:0] month;
		logic [YearW-1:0]  year;
	} cal_res_t;

	// Length of a month given the leap flag of its year
	function automatic logic [LenW-1:0] month_len(input logic [MonthW-1:0] m,
		input logic leap);
		logic [LenW-1:0] len;
		len = LenW'(31);
		case (m)
			MonthW'(4), MonthW'(6), MonthW'(9), MonthW'(11): len = LenW'(30);
			MonthFeb: len = leap ? LenW'(29) : LenW'(28);
			default: len = LenW'(31);
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== src/dcft_cal_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcft_cal_seq: calendar sequencer
// Peels whole years, then whole months, off a day count with one shared
// compare-and-subtract unit, one step per cycle.
// ----------------------------------------------------------------------------
module dcft_cal_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [dcft_pkg::DayCountW-1:0] day_count,
	output logic                                idle,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output dcft_pkg::cal_res_t                  res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_YEAR,
		S_MONTH,
		S_HOLD
	} state_t;

	state_t                            state_q;
	logic [dcft_pkg::DayCountW-1:0]    dd_q;
	logic [dcft_pkg::YearW-1:0]        year_q;
	logic [dcft_pkg::MonthW-1:0]       month_q;
	logic [dcft_pkg::Mod4W-1:0]        y4_q;
	logic [dcft_pkg::Mod100W-1:0]      y100_q;
	logic [dcft_pkg::Mod400W-1:0]      y400_q;

	logic                              leap;
	logic [dcft_pkg::LenW-1:0]         len;
	logic [dcft_pkg::DayCountW:0]      diff;
	logic                              gt;

	// Leap rule from the running remainders
	assign leap = ((y4_q == '0) && (y100_q != '0)) || (y400_q == '0);

	// Shared unit: amount to take off this step, and dd > amount
	always_comb begin
		if (state_q == S_YEAR) begin
			len = leap ? dcft_pkg::DaysLeapYear : dcft_pkg::DaysYear;
		end else begin
			len = dcft_pkg::month_len(month_q, leap);
		end
		diff = {1'b0, dd_q} - {{(dcft_pkg::DayCountW + 1 - dcft_pkg::LenW){1'b0}}, len};
		gt   = !diff[dcft_pkg::DayCountW] && (diff[dcft_pkg::DayCountW-1:0] != '0);
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_HOLD);
	assign res.day   = dd_q[dcft_pkg::DayW-1:0];
	assign res.month = month_q;
	assign res.year  = year_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dd_q    <= '0;
			year_q  <= dcft_pkg::EpochYear;
			month_q <= dcft_pkg::MonthJan;
			y4_q    <= dcft_pkg::EpochMod4;
			y100_q  <= dcft_pkg::EpochMod100;
			y400_q  <= dcft_pkg::EpochMod400;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_YEAR;
						dd_q    <= day_count;
						year_q  <= dcft_pkg::EpochYear;
						month_q <= dcft_pkg::MonthJan;
						y4_q    <= dcft_pkg::EpochMod4;
						y100_q  <= dcft_pkg::EpochMod100;
						y400_q  <= dcft_pkg::EpochMod400;
					end
				end
				S_YEAR: begin
					if (gt) begin
						dd_q   <= diff[dcft_pkg::DayCountW-1:0];
						year_q <= year_q + 1'b1;
						y4_q   <= y4_q + 1'b1;
						y100_q <= (y100_q == dcft_pkg::Cent) ? '0 : y100_q + 1'b1;
						y400_q <= (y400_q == dcft_pkg::QuadCent) ? '0 : y400_q + 1'b1;
					end else begin
						state_q <= S_MONTH;
					end
				end
				S_MONTH: begin
					if (gt && (month_q != dcft_pkg::MonthDec)) begin
						dd_q    <= diff[dcft_pkg::DayCountW-1:0];
						month_q <= month_q + 1'b1;
					end else begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/dcft_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcft_pack: FAT word packer
// Converts the BCD time of day to binary and builds the FAT date and time
// words from the calendar result.
// ----------------------------------------------------------------------------
module dcft_pack (
	input  wire dcft_pkg::cal_res_t           res,
	input  wire logic [dcft_pkg::HourW-1:0]   hour_bcd,
	input  wire logic [dcft_pkg::MinuteW-1:0] minute_bcd,
	input  wire logic [dcft_pkg::SecondW-1:0] second_bcd,
	output logic [dcft_pkg::FatW-1:0]         fat_date,
	output logic [dcft_pkg::FatW-1:0]         fat_time
);

	localparam logic [6:0] FatEpochLow = dcft_pkg::FatEpochYear[6:0];

	logic [5:0] hour_bin;
	logic [6:0] minute_bin;
	logic [6:0] second_bin;
	logic [6:0] year_ofs;

	// tens * 10 + ones, nibbles taken as they come
	assign hour_bin   = 6'({hour_bcd[5:4], 3'b000}) + 6'({hour_bcd[5:4], 1'b0})
		+ 6'(hour_bcd[3:0]);
	assign minute_bin = 7'({minute_bcd[6:4], 3'b000}) + 7'({minute_bcd[6:4], 1'b0})
		+ 7'(minute_bcd[3:0]);
	assign second_bin = 7'({second_bcd[6:4], 3'b000}) + 7'({second_bcd[6:4], 1'b0})
		+ 7'(second_bcd[3:0]);

	// Year field wraps modulo 128
	assign year_ofs = res.year[6:0] - FatEpochLow;
	assign fat_date = {year_ofs, res.month, res.day};

	// Fields are added so oversize values carry upward
	assign fat_time = 16'(second_bin[6:1]) + {4'b0000, minute_bin, 5'b00000}
		+ {hour_bin[4:0], 11'b0};

endmodule
`default_nettype wire

// ===== src/day_count_to_fat_timestamp_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// After an input transfer the sequencer peels whole years (0 to 179), then whole
// months (0 to 11), holds the result, and the output register raises m_tvalid.
// One item at a time: s_tready stays low until the sequencer is idle again, and
// stays low longer while a result waits in the output register.
// Reset (arst_n low, asynchronous) empties the output and idles the sequencer.
// ----------------------------------------------------------------------------
// day_count_to_fat_timestamp_unit: day count to FAT timestamp converter
// Streams in a day count and BCD time of day, streams out day, month, year
// and the FAT date and time words.
// ----------------------------------------------------------------------------
module day_count_to_fat_timestamp_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// day_count[15:0], hour_bcd[21:16], minute_bcd[28:22], second_bcd[35:29]
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// day_of_month[4:0], month_number[8:5], calendar_year[20:9],
	// fat_date[36:21], fat_time[52:37]
	output logic [55:0]      m_tdata
);

	logic                                seq_idle;
	logic                                res_valid;
	logic                                res_ready;
	logic                                in_xfer;
	dcft_pkg::cal_res_t                  res;
	logic [dcft_pkg::HourW-1:0]          hour_q;
	logic [dcft_pkg::MinuteW-1:0]        minute_q;
	logic [dcft_pkg::SecondW-1:0]        second_q;
	logic [dcft_pkg::FatW-1:0]           fat_date;
	logic [dcft_pkg::FatW-1:0]           fat_time;
	logic                                m_tvalid_q;
	logic [52:0]                         out_q;

	assign s_tready  = seq_idle;
	assign in_xfer   = s_tvalid && s_tready;
	assign res_ready = !m_tvalid_q || m_tready;

	// Time of day held for the whole conversion
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			hour_q   <= s_tdata[21:16];
			minute_q <= s_tdata[28:22];
			second_q <= s_tdata[35:29];
		end
	end

	dcft_cal_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer),
		.day_count (s_tdata[15:0]),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	dcft_pack u_pack (
		.res        (res),
		.hour_bcd   (hour_q),
		.minute_bcd (minute_q),
		.second_bcd (second_q),
		.fat_date   (fat_date),
		.fat_time   (fat_time)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= {fat_time, fat_date, res.year, res.month, res.day};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_q};

endmodule
`default_nettype wire

// ===== test/dcft_stamp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcft_stamp_checker: result checker for the day count to FAT timestamp unit
// Watches both stream channels. Each input transfer is turned into the
// calendar date and FAT words it should produce. Each output transfer is
// compared field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module dcft_stamp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// day_count[15:0], hour_bcd[21:16], minute_bcd[28:22], second_bcd[35:29]
	input  wire logic [39:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// day_of_month[4:0], month_number[8:5], calendar_year[20:9],
	// fat_date[36:21], fat_time[52:37]
	input  wire logic [55:0] m_tdata,
	output int               items_taken,
	output int               results_checked,
	output int               mismatches
);

	typedef struct packed {
		logic [dcft_pkg::DayW-1:0]   day;
		logic [dcft_pkg::MonthW-1:0] month;
		logic [dcft_pkg::YearW-1:0]  year;
		logic [dcft_pkg::FatW-1:0]   fat_date;
		logic [dcft_pkg::FatW-1:0]   fat_time;
	} stamp_t;

	stamp_t pending_stamps[$];

	function automatic bit is_leap(input int unsigned yr);
		return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned mon,
		input int unsigned yr);
		if (mon == 4 || mon == 6 || mon == 9 || mon == 11)
			return 30;
		if (mon == 2)
			return is_leap(yr) ? 29 : 28;
		return 31;
	endfunction

	// tens*10 + ones, nibbles above 9 are taken at face value
	function automatic int unsigned bcd_digits(input logic [6:0] v);
		int unsigned tens, ones;
		tens = v[6:4];
		ones = v[3:0];
		return tens * 10 + ones;
	endfunction

	function automatic stamp_t predict_stamp(input logic [39:0] word);
		int unsigned days, yr, mon, mlen, hr, mi, se, date_w, time_w;
		stamp_t st;
		days = word[15:0];
		hr   = bcd_digits({1'b0, word[21:16]});
		mi   = bcd_digits(word[28:22]);
		se   = bcd_digits(word[35:29]);
		yr   = dcft_pkg::EpochYearI;
		mon  = 1;
		// strip whole years; the last day of a leap year stays in that year
		while (days > 365 && (days != 366 || !is_leap(yr))) begin
			days -= is_leap(yr) ? 366 : 365;
			yr++;
		end
		// then whole months
		mlen = days_in_month(mon, yr);
		while (mon < 12 && days > mlen) begin
			days -= mlen;
			mon++;
			mlen = days_in_month(mon, yr);
		end
		// fields are added, so oversized values carry upward
		date_w = days + (mon << 5) + (((yr - dcft_pkg::FatEpochYearI) & 127) << 9);
		time_w = se / 2 + (mi << 5) + (hr << 11);
		st.day      = days[dcft_pkg::DayW-1:0];
		st.month    = mon[dcft_pkg::MonthW-1:0];
		st.year     = yr[dcft_pkg::YearW-1:0];
		st.fat_date = date_w[dcft_pkg::FatW-1:0];
		st.fat_time = time_w[dcft_pkg::FatW-1:0];
		return st;
	endfunction

	function automatic int field_bad(input string name, input int unsigned exp_v,
		input int unsigned got_v);
		if (exp_v == got_v)
			return 0;
		$error("%s: expected %0d (0x%0h), got %0d (0x%0h)", name, exp_v, exp_v,
			got_v, got_v);
		return 1;
	endfunction

	// Track transfers on both channels
	always @(posedge clk or negedge arst_n) begin
		stamp_t want;
		int bad;
		if (!arst_n) begin
			pending_stamps.delete();
			items_taken     <= 0;
			results_checked <= 0;
			mismatches      <= 0;
		end else begin
			bad = 0;
			// result side first: a result never belongs to an item taken this edge
			if (m_tvalid && m_tready) begin
				if (pending_stamps.size() == 0) begin
					$error("result 0x%0h arrived with no timestamp outstanding", m_tdata);
					bad = 1;
				end else begin
					want = pending_stamps.pop_front();
					bad += field_bad("day_of_month", want.day, m_tdata[4:0]);
					bad += field_bad("month_number", want.month, m_tdata[8:5]);
					bad += field_bad("calendar_year", want.year, m_tdata[20:9]);
					bad += field_bad("fat_date", want.fat_date, m_tdata[36:21]);
					bad += field_bad("fat_time", want.fat_time, m_tdata[52:37]);
					results_checked <= results_checked + 1;
				end
			end
			if (s_tvalid && s_tready) begin
				pending_stamps.push_back(predict_stamp(s_tdata));
				items_taken <= items_taken + 1;
			end
			if (bad != 0)
				mismatches <= mismatches + bad;
		end
	end

endmodule

// ===== test/day_count_to_fat_timestamp_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_count_to_fat_timestamp_unit_tb: testbench for the timestamp converter
// Drives calendar edge cases, then random day counts and BCD times in bursts
// against a randomly stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module day_count_to_fat_timestamp_unit_tb;

	localparam int RandomItems   = 1150;
	localparam int DirectedItems = 20;
	localparam int PressureAt    = 500;
	localparam int DrainCycles   = 220;
	localparam int WatchdogLimit = 4000;

	// receiver stall patterns
	localparam int ReadyAlways   = 0;
	localparam int ReadyCoin     = 1;
	localparam int ReadyRare     = 2;
	localparam int ReadyPeriodic = 3;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// day_count[15:0], hour_bcd[21:16], minute_bcd[28:22], second_bcd[35:29]
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// day_of_month[4:0], month_number[8:5], calendar_year[20:9],
	// fat_date[36:21], fat_time[52:37]
	logic [55:0] m_tdata;

	int items_taken, results_checked, mismatches;
	int burst_left, odd_bcd_items, idle_cycles;
	int stall_mode, phase_left;
	bit sender_live;

	// Directed day counts: epoch edges, month and year ends, leap days,
	// the century rules for 2000 and 2100, and the largest count
	int unsigned edge_days[DirectedItems] = '{0, 1, 31, 32, 59, 60, 365, 366,
		730, 731, 790, 791, 1096, 1097, 8095, 8401, 44620, 44925, 44926, 65535};
	logic [5:0] edge_hour[5]   = '{6'h00, 6'h23, 6'h3F, 6'h12, 6'h19};
	logic [6:0] edge_minute[5] = '{7'h00, 7'h59, 7'h7F, 7'h34, 7'h5A};
	logic [6:0] edge_second[5] = '{7'h00, 7'h59, 7'h7F, 7'h56, 7'h0F};

	day_count_to_fat_timestamp_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	dcft_stamp_checker stamp_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.items_taken    (items_taken),
		.results_checked(results_checked),
		.mismatches     (mismatches)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver: each phase picks a stall pattern for a random stretch
	always @(negedge clk) begin
		if (phase_left == 0) begin
			stall_mode <= $urandom_range(ReadyAlways, ReadyPeriodic);
			phase_left <= $urandom_range(20, 300);
		end else begin
			phase_left <= phase_left - 1;
		end
		case (stall_mode)
			ReadyAlways:   m_tready <= 1'b1;
			ReadyCoin:     m_tready <= ($urandom_range(0, 1) == 1);
			ReadyRare:     m_tready <= ($urandom_range(0, 7) == 0);
			default:       m_tready <= (phase_left % 5 == 0);
		endcase
	end

	// Watchdog: ends the run after too long without any transfer
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WatchdogLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", WatchdogLimit);
		$display("day_count_to_fat_timestamp_unit_tb: FAIL");
		$finish;
	end

	task automatic drop_valid();
		if (sender_live) begin
			s_tvalid <= 1'b0;
			sender_live = 1'b0;
		end
	endtask

	// One transfer, then the burst/gap schedule of the sender
	task automatic send_stamp(input logic [15:0] days, input logic [5:0] hr,
		input logic [6:0] mi, input logic [6:0] se);
		int gap;
		s_tdata  <= {4'b0, se, mi, hr, days};
		s_tvalid <= 1'b1;
		sender_live = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(0, 9) < 3) begin
			// a stretch with no gaps
			burst_left = $urandom_range(20, 60);
		end else begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(1, 10);
			drop_valid();
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [6:0] to_bcd(input int unsigned v);
		return {3'(v / 10), 4'(v % 10)};
	endfunction

	// Stimulus
	initial begin
		logic [15:0] days;
		logic [5:0]  hr;
		logic [6:0]  mi, se;
		int          pick;
		burst_left = 0;
		sender_live = 1'b0;
		odd_bcd_items = 0;
		stall_mode = ReadyAlways;
		phase_left = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DirectedItems; i++)
			send_stamp(16'(edge_days[i]), edge_hour[i % 5], edge_minute[i % 5],
				edge_second[i % 5]);

		for (int i = 0; i < RandomItems; i++) begin
			if (i == PressureAt) begin
				// hold off until every timestamp has come back
				drop_valid();
				while (items_taken != results_checked) @(negedge clk);
			end
			pick = $urandom_range(0, 9);
			if (pick < 5)
				days = 16'($urandom_range(0, 65535));
			else if (pick < 8)
				days = 16'($urandom_range(0, 1500));
			else
				days = 16'($urandom_range(7900, 9000));
			if ($urandom_range(0, 4) == 0) begin
				// raw bit patterns: non-decimal digits and carries into next field
				hr = 6'($urandom);
				mi = 7'($urandom);
				se = 7'($urandom);
				if (hr[3:0] > 9 || mi[3:0] > 9 || se[3:0] > 9 || mi[6:4] > 5 ||
					se[6:4] > 5 || hr > 6'h23)
					odd_bcd_items++;
			end else begin
				hr = 6'(to_bcd($urandom_range(0, 23)));
				mi = to_bcd($urandom_range(0, 59));
				se = to_bcd($urandom_range(0, 59));
			end
			send_stamp(days, hr, mi, se);
		end
		drop_valid();

		while (items_taken != results_checked) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("converted %0d timestamps: %0d calendar edge cases, %0d random with %0d",
			results_checked, DirectedItems, RandomItems, odd_bcd_items);
		$display("  out-of-range BCD times, under bursty input and a stalling receiver");
		if (mismatches == 0 && items_taken == results_checked)
			$display("day_count_to_fat_timestamp_unit_tb: PASS");
		else
			$display("day_count_to_fat_timestamp_unit_tb: FAIL");
		$finish;
	end

endmodule

// ===== day_count_to_fat_timestamp_unit.f =====
src/dcft_pkg.sv
src/dcft_cal_seq.sv
src/dcft_pack.sv
src/day_count_to_fat_timestamp_unit.sv
test/dcft_stamp_checker.sv
test/day_count_to_fat_timestamp_unit_tb.sv
